// ===== sv/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types and constants for the byte classifier, the request queue and
// the sequence assembler.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  // Byte classes produced by the front end.
  localparam logic [2:0] KIND_ASCII = 3'd0;
  localparam logic [2:0] KIND_LEAD2 = 3'd1;
  localparam logic [2:0] KIND_LEAD3 = 3'd2;
  localparam logic [2:0] KIND_LEAD4 = 3'd3;
  localparam logic [2:0] KIND_CONT  = 3'd4;
  localparam logic [2:0] KIND_BAD   = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_CAPACITY = 2'd2;

  localparam int          CP_W       = 21;
  localparam int          CAP_W      = 16;
  localparam logic [15:0] CAP_RESET  = 16'd256;
  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;

  // Queue between the classifier and the assembler.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified byte. The payload holds the seven ASCII bits, the masked
  // lead bits or the six continuation bits, right aligned.
  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] bits;
    logic       eos;
  } item_t;

endpackage

// ===== sv/utf8d_if.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder channel interfaces
// Valid/ready channels for incoming bytes and outgoing decode results.
// ----------------------------------------------------------------------------
interface utf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface utf8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] codepoint;
  logic        has_codepoint;
  logic [1:0]  status;
  logic        done_res;
  logic [15:0] out_count;

  modport source (output valid, output codepoint, output has_codepoint, output status,
                  output done_res, output out_count, input ready);
  modport sink   (input valid, input codepoint, input has_codepoint, input status,
                  input done_res, input out_count, output ready);
endinterface

// ===== sv/utf8d_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 byte classifier
// Accepts bytes from the input channel and sorts each into a byte class.
// ----------------------------------------------------------------------------
module utf8d_front (
  utf8d_in_if.sink         in_ch,
  input  logic             q_full,
  output logic             push,
  output utf8d_pkg::item_t item
);

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    item.eos  = in_ch.end_of_string;
    item.bits = in_ch.data_byte[6:0];
    if (in_ch.data_byte[7] == 1'b0) begin
      item.kind = utf8d_pkg::KIND_ASCII;
    end else if (in_ch.data_byte[7:6] == 2'b10) begin
      item.kind = utf8d_pkg::KIND_CONT;
      item.bits = {1'b0, in_ch.data_byte[5:0]};
    end else if (in_ch.data_byte[7:5] == 3'b110) begin
      item.kind = utf8d_pkg::KIND_LEAD2;
      item.bits = {2'b00, in_ch.data_byte[4:0]};
    end else if (in_ch.data_byte[7:4] == 4'b1110) begin
      item.kind = utf8d_pkg::KIND_LEAD3;
      item.bits = {3'b000, in_ch.data_byte[3:0]};
    end else if (in_ch.data_byte[7:3] == 5'b11110) begin
      item.kind = utf8d_pkg::KIND_LEAD4;
      item.bits = {4'b0000, in_ch.data_byte[2:0]};
    end else begin
      item.kind = utf8d_pkg::KIND_BAD;
    end
  end

endmodule

// ===== sv/utf8d_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder request queue
// A short first-in first-out store of classified bytes.
// ----------------------------------------------------------------------------
module utf8d_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  utf8d_pkg::item_t push_item,
  input  logic             pop,
  output utf8d_pkg::item_t head,
  output logic             full,
  output logic             empty
);

  utf8d_pkg::item_t                    store_r [utf8d_pkg::QUEUE_DEPTH];
  logic [utf8d_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [utf8d_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [utf8d_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;

  assign full  = (cnt_r == utf8d_pkg::QCNT_W'(utf8d_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == utf8d_pkg::QPTR_W'(utf8d_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == utf8d_pkg::QPTR_W'(utf8d_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("request pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("request popped from an empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= utf8d_pkg::QCNT_W'(utf8d_pkg::QUEUE_DEPTH))
    else $error("queue occupancy beyond its depth");
`endif

endmodule

// ===== sv/utf8d_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sequence assembler
// Builds codepoints from classified bytes, tracks errors and the per-string
// count, and holds each result in an output register.
// ----------------------------------------------------------------------------
module utf8d_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata,
  input  logic             q_empty,
  input  utf8d_pkg::item_t item,
  output logic             pop,
  utf8d_out_if.source      out_ch
);

  localparam int CMP_W = (COUNT_BITS > utf8d_pkg::CAP_W) ? COUNT_BITS : utf8d_pkg::CAP_W;

  logic [15:0]           cap_r;
  logic [20:0]           acc_r, acc_nxt;
  logic [1:0]            pend_r, pend_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  err_r, err_nxt;
  logic [1:0]            code_r, code_nxt;

  logic                  ov_r;
  logic [20:0]           ocp_r;
  logic                  ohave_r;
  logic [1:0]            ost_r;
  logic                  odone_r;
  logic [15:0]           ocnt_r;

  logic                  have;
  logic [20:0]           cp;
  logic [20:0]           acc_sh;
  logic                  at_cap;
  logic                  produce;
  logic [CMP_W-1:0]      cnt_ext;

  assign pop     = !q_empty && (!ov_r || out_ch.ready);
  assign at_cap  = (CMP_W'(cnt_r) >= CMP_W'(cap_r)) || (&cnt_r);
  assign acc_sh  = {acc_r[14:0], item.bits[5:0]};

  always_comb begin
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    code_nxt = code_r;
    have     = 1'b0;
    cp       = '0;
    if (!err_r) begin
      if (pend_r == 2'd0) begin
        if (at_cap) begin
          err_nxt  = 1'b1;
          code_nxt = utf8d_pkg::ST_CAPACITY;
        end else begin
          unique case (item.kind)
            utf8d_pkg::KIND_ASCII: begin
              cp   = {14'd0, item.bits};
              have = 1'b1;
            end
            utf8d_pkg::KIND_LEAD2: begin
              acc_nxt  = {14'd0, item.bits};
              pend_nxt = 2'd1;
            end
            utf8d_pkg::KIND_LEAD3: begin
              acc_nxt  = {14'd0, item.bits};
              pend_nxt = 2'd2;
            end
            utf8d_pkg::KIND_LEAD4: begin
              acc_nxt  = {14'd0, item.bits};
              pend_nxt = 2'd3;
            end
            default: begin
              err_nxt  = 1'b1;
              code_nxt = utf8d_pkg::ST_INVALID;
            end
          endcase
        end
      end else if (item.kind != utf8d_pkg::KIND_CONT) begin
        err_nxt  = 1'b1;
        code_nxt = utf8d_pkg::ST_INVALID;
        pend_nxt = 2'd0;
        acc_nxt  = '0;
      end else begin
        pend_nxt = pend_r - 2'd1;
        acc_nxt  = acc_sh;
        if (pend_r == 2'd1) begin
          cp      = acc_sh;
          acc_nxt = '0;
          have    = 1'b1;
        end
      end
      // Surrogate halves are rejected rather than emitted.
      if (have && cp >= utf8d_pkg::SURR_LO && cp <= utf8d_pkg::SURR_HI) begin
        have     = 1'b0;
        cp       = '0;
        err_nxt  = 1'b1;
        code_nxt = utf8d_pkg::ST_INVALID;
      end
      // A sequence cut short by the end of the string.
      if (!err_nxt && pend_nxt != 2'd0 && item.eos) begin
        err_nxt  = 1'b1;
        code_nxt = utf8d_pkg::ST_INVALID;
        pend_nxt = 2'd0;
        acc_nxt  = '0;
      end
      if (have) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  assign produce = have || item.eos;
  assign cnt_ext = CMP_W'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= utf8d_pkg::CAP_RESET;
      acc_r  <= '0;
      pend_r <= '0;
      cnt_r  <= '0;
      err_r  <= 1'b0;
      code_r <= utf8d_pkg::ST_OK;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (pop) begin
        if (item.eos) begin
          acc_r  <= '0;
          pend_r <= '0;
          cnt_r  <= '0;
          err_r  <= 1'b0;
          code_r <= utf8d_pkg::ST_OK;
        end else begin
          acc_r  <= acc_nxt;
          pend_r <= pend_nxt;
          cnt_r  <= cnt_nxt;
          err_r  <= err_nxt;
          code_r <= code_nxt;
        end
      end
      if (pop && produce) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && produce) begin
      ocp_r   <= cp;
      ohave_r <= have;
      ost_r   <= err_nxt ? code_nxt : utf8d_pkg::ST_OK;
      odone_r <= item.eos;
      ocnt_r  <= cnt_ext[15:0];
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.codepoint     = ocp_r;
  assign out_ch.has_codepoint = ohave_r;
  assign out_ch.status        = ost_r;
  assign out_ch.done_res      = odone_r;
  assign out_ch.out_count     = ocnt_r;

`ifndef SYNTH
  a_cp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ohave_r |-> ost_r == utf8d_pkg::ST_OK)
    else $error("codepoint result carries an error status");
  a_mid_has_cp: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !odone_r |-> ohave_r)
    else $error("mid-string result without a codepoint");
  a_err_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> pend_r == 2'd0 && acc_r == '0)
    else $error("sequence still pending after an error");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ch.ready |=> ov_r && $stable(ocnt_r) && $stable(ocp_r))
    else $error("held result changed while stalled");
`endif

endmodule

// ===== sv/utf8_to_codepoint_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to codepoint decoder
// Decodes a stream of UTF-8 bytes into codepoints, one byte per clock while out_ch is not stalled.
// ----------------------------------------------------------------------------
// Usage:
// The in_ch channel carries one byte per request, with end_of_string set on
// the last byte of each string. The out_ch channel delivers a result for
// every completed codepoint and one final result on the last byte, which
// carries done_res, the string's status and its codepoint count.
// cfg_we with cfg_wdata sets the per-string codepoint capacity (256 after
// reset); write it only while the block is idle.
// Throughput is one byte per clock while out_ch is not stalled. A byte
// accepted on in_ch is classified and written into the queue, is taken
// from the queue head by the assembler, and its result, if any, is
// registered in the output register and presented on out_ch. The
// assembler loop, which folds six bits into the accumulator and checks
// the count against capacity, sets that rate.
// When the receiver stalls, the output register holds its result, the
// two-entry queue soaks up the bytes in flight, and in_ch.ready falls only
// once the queue is full. Synchronous reset clears the queue, the output
// register and the string state, and restores the capacity.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  utf8d_in_if.sink    in_ch,
  utf8d_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  // Handshake between the classifier, the queue and the assembler.
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  utf8d_pkg::item_t push_item;
  utf8d_pkg::item_t head;

  // Front end: classifies each byte as it is accepted.
  utf8d_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .item   (push_item)
  );

  // Queue: lets the front accept while the back waits on the receiver.
  utf8d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: assembles sequences and owns the result register.
  utf8d_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .item      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== verif/tb_utf8_to_codepoint_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder testbench
// Drives byte strings into the decoder under random back-pressure and checks
// every result against a cycle-free model of the byte-level decoding rules.
// The run opens with a hand-written script of sequences and error cases,
// then moves through several capacity settings with random strings.
// ----------------------------------------------------------------------------
module tb_utf8_to_codepoint_decoder_unit;

  // The random part stops once about this many bytes have been sent.
  localparam int RANDOM_ITEMS  = 1250;
  localparam int N_PHASES      = 8;
  // Ample slack for a byte to pass the queue and the output register.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [utf8d_pkg::CP_W-1:0]  codepoint;
    logic                        has_codepoint;
    logic [1:0]                  status;
    logic                        done_res;
    logic [utf8d_pkg::CAP_W-1:0] out_count;
  } result_t;

  // A script row either sends one byte or sets a new capacity.
  typedef enum {ROW_BYTE, ROW_CAP} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [utf8d_pkg::CAP_W-1:0] value;
    logic                        eos;
    bit                          known;
    result_t                     want;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  utf8d_in_if  in_if ();
  utf8d_out_if out_if ();

  utf8_to_codepoint_decoder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Decoder model state: one copy of the string state and the capacity.
  logic [utf8d_pkg::CAP_W-1:0] dec_cap;
  logic [utf8d_pkg::CP_W-1:0]  dec_acc;
  logic [1:0]                  dec_pending;
  logic [utf8d_pkg::CAP_W-1:0] dec_count;
  logic                        dec_err;
  logic [1:0]                  dec_err_code;

  // Results that the model has predicted and the block has not yet delivered.
  result_t results_due[$];
  row_t    script[$];

  int fail_count  = 0;
  int cycle_count = 0;
  int live_bytes  = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int stall_left  = 0;

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  function automatic void clear_string();
    dec_acc      = '0;
    dec_pending  = '0;
    dec_count    = '0;
    dec_err      = 1'b0;
    dec_err_code = utf8d_pkg::ST_OK;
  endfunction

  // The first error of a string is kept; the partial sequence is dropped.
  function automatic void latch_fault(input logic [1:0] code);
    dec_err      = 1'b1;
    dec_err_code = code;
    dec_pending  = '0;
    dec_acc      = '0;
  endfunction

  // Advances the model by one byte. Returns 1 when the byte yields a result.
  function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                     output result_t res);
    logic                       have;
    logic [utf8d_pkg::CP_W-1:0] cp;
    have = 1'b0;
    cp   = '0;
    res  = '0;
    if (!dec_err) begin
      if (dec_pending == 0) begin
        // The capacity test comes before the byte itself is looked at.
        if (dec_count >= dec_cap || dec_count == {utf8d_pkg::CAP_W{1'b1}}) begin
          latch_fault(utf8d_pkg::ST_CAPACITY);
        end else if (b[7] == 1'b0) begin
          cp   = utf8d_pkg::CP_W'(b[6:0]);
          have = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          dec_acc     = utf8d_pkg::CP_W'(b[4:0]);
          dec_pending = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          dec_acc     = utf8d_pkg::CP_W'(b[3:0]);
          dec_pending = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          dec_acc     = utf8d_pkg::CP_W'(b[2:0]);
          dec_pending = 2'd3;
        end else begin
          latch_fault(utf8d_pkg::ST_INVALID);
        end
      end else begin
        if (b[7:6] != 2'b10) begin
          latch_fault(utf8d_pkg::ST_INVALID);
        end else begin
          dec_acc     = {dec_acc[utf8d_pkg::CP_W-7:0], b[5:0]};
          dec_pending = dec_pending - 2'd1;
          if (dec_pending == 0) begin
            cp      = dec_acc;
            dec_acc = '0;
            have    = 1'b1;
          end
        end
      end
      if (have && cp >= utf8d_pkg::SURR_LO && cp <= utf8d_pkg::SURR_HI) begin
        have = 1'b0;
        cp   = '0;
        latch_fault(utf8d_pkg::ST_INVALID);
      end
      if (!dec_err && dec_pending != 0 && eos) begin
        latch_fault(utf8d_pkg::ST_INVALID);
      end
      if (have) begin
        dec_count = dec_count + 1'b1;
      end
    end
    if (!have && !eos) begin
      return 1'b0;
    end
    res.codepoint     = cp;
    res.has_codepoint = have;
    res.status        = dec_err ? dec_err_code : utf8d_pkg::ST_OK;
    res.done_res      = eos;
    res.out_count     = dec_count;
    if (eos) begin
      clear_string();
    end
    return 1'b1;
  endfunction

  function automatic result_t mk_result(input logic [utf8d_pkg::CP_W-1:0] cp,
                                        input logic has,
                                        input logic [1:0] st, input logic done,
                                        input logic [utf8d_pkg::CAP_W-1:0] cnt);
    result_t r;
    r.codepoint     = cp;
    r.has_codepoint = has;
    r.status        = st;
    r.done_res      = done;
    r.out_count     = cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed script
  // ---------------------------------------------------------------------------

  function automatic void row_byte(input logic [7:0] b, input logic eos);
    script.push_back('{ROW_BYTE, utf8d_pkg::CAP_W'(b), eos, 1'b0, '0});
  endfunction

  function automatic void row_known(input logic [7:0] b, input logic eos,
                                    input result_t want);
    script.push_back('{ROW_BYTE, utf8d_pkg::CAP_W'(b), eos, 1'b1, want});
  endfunction

  function automatic void row_cap(input logic [utf8d_pkg::CAP_W-1:0] v);
    script.push_back('{ROW_CAP, v, 1'b0, 1'b0, '0});
  endfunction

  // The expected result is written out only where it is obvious; the model
  // fills in the rest.
  function automatic void build_script();
    // One string holding every sequence length, ending on the largest value
    // that a four-byte sequence can carry, completed by the last byte itself.
    row_known(8'h00, 1'b0, mk_result('0, 1'b1, utf8d_pkg::ST_OK, 1'b0, 16'd1));
    row_known(8'h7F, 1'b0, mk_result(21'h7F, 1'b1, utf8d_pkg::ST_OK, 1'b0, 16'd2));
    row_byte(8'hC2, 1'b0);
    row_byte(8'h80, 1'b0);
    row_byte(8'hE2, 1'b0);
    row_byte(8'h82, 1'b0);
    row_byte(8'hAC, 1'b0);
    row_byte(8'hF4, 1'b0);
    row_byte(8'h8F, 1'b0);
    row_byte(8'hBF, 1'b0);
    row_byte(8'hBF, 1'b0);
    row_byte(8'hF7, 1'b0);
    row_byte(8'hBF, 1'b0);
    row_byte(8'hBF, 1'b0);
    row_known(8'hBF, 1'b1, mk_result(21'h1FFFFF, 1'b1, utf8d_pkg::ST_OK, 1'b1, 16'd6));
    // A stray continuation byte.
    row_known(8'h80, 1'b1, mk_result('0, 1'b0, utf8d_pkg::ST_INVALID, 1'b1, '0));
    // A lead byte of 0xF8 or above; the following byte is absorbed.
    row_byte(8'hFF, 1'b0);
    row_known(8'h41, 1'b1, mk_result('0, 1'b0, utf8d_pkg::ST_INVALID, 1'b1, '0));
    // A bad continuation byte.
    row_byte(8'hC3, 1'b0);
    row_known(8'h41, 1'b1, mk_result('0, 1'b0, utf8d_pkg::ST_INVALID, 1'b1, '0));
    // A sequence cut short by the end of the string.
    row_known(8'hE0, 1'b1, mk_result('0, 1'b0, utf8d_pkg::ST_INVALID, 1'b1, '0));
    // A surrogate value, which is not emitted.
    row_byte(8'hED, 1'b0);
    row_byte(8'hA0, 1'b0);
    row_known(8'h80, 1'b1, mk_result('0, 1'b0, utf8d_pkg::ST_INVALID, 1'b1, '0));
    // Capacity reached after one codepoint, and a capacity of zero.
    row_cap(16'd1);
    row_byte(8'h41, 1'b0);
    row_known(8'h42, 1'b1, mk_result('0, 1'b0, utf8d_pkg::ST_CAPACITY, 1'b1, 16'd1));
    row_cap(16'd0);
    row_known(8'h41, 1'b1, mk_result('0, 1'b0, utf8d_pkg::ST_CAPACITY, 1'b1, '0));
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(6, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  // Presents one byte and waits for the request to be taken. Valid stays high
  // after acceptance so that back-to-back bytes need no low cycle; the next
  // call, or settle_decoder, changes it at the following falling edge.
  task automatic send_byte(input logic [7:0] b, input logic eos, input bit known,
                           input result_t want);
    int      gap;
    result_t res;
    gap = ($urandom_range(0, 99) < idle_pct) ? gap_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= b;
    in_if.end_of_string <= eos;
    do @(posedge clk); while (!in_if.ready);
    live_bytes++;
    if (decode_byte(b, eos, res)) begin
      results_due.push_back(known ? want : res);
    end
  endtask

  // Stops sending and waits until every predicted result has been delivered,
  // and then for any bytes still in flight that give no result.
  task automatic settle_decoder();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The capacity is only changed with the decoder drained and idle.
  task automatic write_capacity(input logic [utf8d_pkg::CAP_W-1:0] v);
    settle_decoder();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    dec_cap = v;
  endtask

  // Builds one random string and sends it. Most strings are well formed with
  // random payload bits (overlong forms and the odd surrogate included); some
  // have one byte corrupted or the last byte cut off, and a few are noise.
  task automatic send_random_string();
    logic [7:0]  text[$];
    int          mode;
    int          n_cp;
    int          pick;
    logic [31:0] rnd;
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      repeat ($urandom_range(1, 8)) text.push_back(8'($urandom));
    end else begin
      n_cp = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      repeat (n_cp) begin
        pick = $urandom_range(0, 19);
        rnd  = $urandom;
        if (pick < 5) begin
          text.push_back({1'b0, rnd[6:0]});
        end else if (pick < 10) begin
          text.push_back({3'b110, rnd[4:0]});
          text.push_back({2'b10, rnd[10:5]});
        end else if (pick < 14) begin
          text.push_back({4'b1110, rnd[3:0]});
          text.push_back({2'b10, rnd[9:4]});
          text.push_back({2'b10, rnd[15:10]});
        end else if (pick < 19) begin
          text.push_back({5'b11110, rnd[2:0]});
          text.push_back({2'b10, rnd[8:3]});
          text.push_back({2'b10, rnd[14:9]});
          text.push_back({2'b10, rnd[20:15]});
        end else begin
          text.push_back(8'hED);
          text.push_back({3'b101, rnd[4:0]});
          text.push_back({2'b10, rnd[10:5]});
        end
      end
      if (mode < 20) begin
        if ($urandom_range(0, 1) == 1) begin
          text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
        end else if (text.size() > 1) begin
          void'(text.pop_back());
        end
      end
    end
    for (int i = 0; i < text.size(); i++) begin
      send_byte(text[i], i == text.size() - 1, 1'b0, '0);
    end
  endtask

  // The receiver stalls at random, in runs of mostly short length.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_if.ready <= 1'b0;
      stall_left = gap_len() - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_failure(input string what, input result_t want, input result_t got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%s at cycle %0d: expected cp=%h has=%b st=%0d done=%b cnt=%0d,",
               what, cycle_count, want.codepoint, want.has_codepoint, want.status,
               want.done_res, want.out_count);
      $display("  got cp=%h has=%b st=%0d done=%b cnt=%0d",
               got.codepoint, got.has_codepoint, got.status, got.done_res,
               got.out_count);
    end
  endtask

  // Every delivered result is matched against the oldest prediction. Values
  // are read at the rising edge, before the block updates its registers.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = mk_result(out_if.codepoint, out_if.has_codepoint, out_if.status,
                      out_if.done_res, out_if.out_count);
      if (results_due.size() == 0) begin
        note_failure("unexpected result", '0, got);
      end else begin
        want = results_due.pop_front();
        if (got.codepoint !== want.codepoint || got.has_codepoint !== want.has_codepoint ||
            got.status !== want.status || got.done_res !== want.done_res ||
            got.out_count !== want.out_count) begin
          note_failure("result mismatch", want, got);
        end
      end
    end
  end

  // A stuck handshake ends the run here rather than hanging it.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [utf8d_pkg::CAP_W-1:0] phase_caps[N_PHASES];
    int                          target;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.end_of_string = 1'b0;
    out_if.ready        = 1'b0;
    dec_cap             = utf8d_pkg::CAP_RESET;
    clear_string();
    build_script();

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // The script runs at the reset capacity until its own capacity rows.
    idle_pct  = 25;
    stall_pct = 25;
    foreach (script[i]) begin
      if (script[i].kind == ROW_CAP) begin
        write_capacity(script[i].value);
      end else begin
        send_byte(8'(script[i].value), script[i].eos, script[i].known, script[i].want);
      end
    end

    // Random strings under a range of capacities, both extremes included.
    // Each capacity change first drains the decoder, so the sender pauses
    // until every outstanding result has come back. The first phase runs
    // with no idling on either side.
    phase_caps = '{16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd5, 16'd16, 16'd0, 16'd256};
    phase_caps[6] = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(3, 12));
    for (int p = 0; p < N_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      idle_pct  = (p == 0) ? 0 : $urandom_range(5, 60);
      stall_pct = (p == 0) ? 0 : $urandom_range(5, 60);
      target    = live_bytes + RANDOM_ITEMS / N_PHASES;
      while (live_bytes < target) begin
        send_random_string();
      end
    end

    settle_decoder();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== utf8_to_codepoint_decoder_unit.f =====
sv/utf8d_pkg.sv
sv/utf8d_if.sv
sv/utf8d_front.sv
sv/utf8d_queue.sv
sv/utf8d_back.sv
sv/utf8_to_codepoint_decoder_unit.sv
verif/tb_utf8_to_codepoint_decoder_unit.sv
